// ===== rtl/wfvp_pkg.sv =====
// Shared types and constants for the vocabulary wire-format parser.
`timescale 1ns / 1ps

package wfvp_pkg;

   // Default width limit for declared lengths
   localparam int LEN_BITS_DEFAULT = 32;

   // Results one byte may cause, and result queue depth
   localparam int MAX_RESULTS = 3;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 4;

   // Varint: ten groups of seven bits at most
   localparam logic [3:0] LAST_VARINT_GROUP = 4'd9;

   // Wire types
   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LEN     = 3'd2;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   // Field numbers
   localparam int FIELD_TEXT  = 1;
   localparam int FIELD_SCORE = 2;
   localparam int FIELD_TYPE  = 3;

   // Byte counts of fixed-size fields
   localparam int FIXED32_BYTES = 4;
   localparam int FIXED64_BYTES = 8;

   // Default piece type
   localparam logic [31:0] TYPE_DEFAULT = 32'd1;

   typedef enum logic [2:0] {
      KIND_TEXT_BEGIN = 3'd0,
      KIND_TEXT_BYTE  = 3'd1,
      KIND_PIECE_END  = 3'd2,
      KIND_PARSE_OK   = 3'd3,
      KIND_PARSE_ERR  = 3'd4
   } rsp_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_OVERLONG  = 3'd1,
      ERR_TRUNCATED = 3'd2,
      ERR_OVERRUN   = 3'd3,
      ERR_BAD_WIRE  = 3'd4
   } err_code_type;

   typedef struct packed {
      rsp_kind_type kind;
      logic [7:0]   byte_value;
      logic [31:0]  text_length;
      logic [31:0]  score_bits;
      logic [31:0]  piece_kind;
      err_code_type error_code;
      logic         last_of_run;
   } rsp_item_type;

   // Results of one accepted byte, in order, for the queue
   typedef struct packed {
      rsp_item_type [MAX_RESULTS-1:0] items;
      logic [RES_CNT_W-1:0]           count;
   } push_type;

   // Parser status seen by the top level
   typedef struct packed {
      logic at_start;
      logic stopped;
   } status_type;

endpackage

// ===== rtl/wfvp_decode.sv =====
// Byte decoder: parser state registers and per-byte next-state and result logic.
`timescale 1ns / 1ps

module wfvp_decode #(
   parameter int LEN_BITS = wfvp_pkg::LEN_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 last,
   output wfvp_pkg::push_type   push,
   output wfvp_pkg::status_type status
);
   import wfvp_pkg::*;

   typedef enum logic [3:0] {
      PH_TOP_KEY,
      PH_TOP_LEN,
      PH_TOP_SKIP_VARINT,
      PH_TOP_SKIP_LEN,
      PH_TOP_SKIP_BYTES,
      PH_IN_KEY,
      PH_IN_TEXT_LEN,
      PH_IN_TEXT,
      PH_IN_SCORE,
      PH_IN_TYPE,
      PH_IN_SKIP_VARINT,
      PH_IN_SKIP_LEN,
      PH_IN_SKIP_BYTES
   } phase_type;

   function automatic logic is_inside(input phase_type ph);
      logic r;
      case (ph)
         PH_IN_KEY, PH_IN_TEXT_LEN, PH_IN_TEXT, PH_IN_SCORE, PH_IN_TYPE,
         PH_IN_SKIP_VARINT, PH_IN_SKIP_LEN, PH_IN_SKIP_BYTES: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   phase_type            phase_ff, phase_in;
   logic [63:0]          vval_ff, vval_in;
   logic [3:0]           grp_ff, grp_in;
   logic [2:0]           wire_ff, wire_in;
   logic [LEN_BITS-1:0]  piece_ff, piece_in;
   logic [LEN_BITS-1:0]  field_ff, field_in;
   logic [31:0]          score_ff, score_in;
   logic [31:0]          ptype_ff, ptype_in;
   logic                 stopped_ff, stopped_in;

   logic                 in_piece;
   logic [LEN_BITS-1:0]  pr_dec;
   logic [6:0]           shamt;
   logic [63:0]          vnew;
   logic [63:0]          vscore;
   logic                 v_more;
   logic                 overlong;
   logic                 v_wide;
   logic [2:0]           key_wire;
   logic                 key_text, key_score, key_type;
   logic [LEN_BITS-1:0]  skip_n;
   err_code_type         err;
   logic                 emit_a, emit_b, emit_f, do_clear;
   rsp_item_type         item_a, item_b, item_f;
   rsp_item_type [MAX_RESULTS-1:0] items;
   logic [RES_CNT_W-1:0] res_n;

   // Varint and score byte accumulation
   always_comb begin
      shamt    = {grp_ff, 3'b000} - {3'b000, grp_ff};
      vnew     = vval_ff | ({57'b0, data_byte[6:0]} << shamt);
      vscore   = vval_ff | ({56'b0, data_byte} << {grp_ff[1:0], 3'b000});
      v_more   = data_byte[7];
      overlong = v_more && (grp_ff == LAST_VARINT_GROUP);
      v_wide   = (vnew >> LEN_BITS) != 64'd0;
      key_wire = vnew[2:0];
      key_text  = (vnew[63:3] == 61'(FIELD_TEXT))  && (key_wire == WIRE_LEN);
      key_score = (vnew[63:3] == 61'(FIELD_SCORE)) && (key_wire == WIRE_FIXED32);
      key_type  = (vnew[63:3] == 61'(FIELD_TYPE))  && (key_wire == WIRE_VARINT);
      skip_n   = (key_wire == WIRE_FIXED64) ? LEN_BITS'(FIXED64_BYTES)
                                            : LEN_BITS'(FIXED32_BYTES);
      in_piece = is_inside(phase_ff);
      pr_dec   = in_piece ? piece_ff - LEN_BITS'(1) : piece_ff;
   end

   // Next state and results for one byte
   always_comb begin
      phase_in   = phase_ff;
      vval_in    = vval_ff;
      grp_in     = grp_ff;
      wire_in    = wire_ff;
      piece_in   = pr_dec;
      field_in   = field_ff;
      score_in   = score_ff;
      ptype_in   = ptype_ff;
      stopped_in = stopped_ff;
      err        = ERR_NONE;
      emit_a     = 1'b0;
      emit_b     = 1'b0;
      emit_f     = 1'b0;
      do_clear   = 1'b0;
      item_a     = '0;
      item_b     = '0;
      item_f     = '0;

      if (stopped_ff) begin
         // Drop bytes until the buffer closes
         do_clear = last;
      end else begin
         case (phase_ff)
            PH_TOP_KEY, PH_IN_KEY: begin
               if (overlong) begin
                  err = ERR_OVERLONG;
               end else if (!v_more) begin
                  vval_in = '0;
                  grp_in  = '0;
                  wire_in = key_wire;
                  if (key_text) begin
                     phase_in = in_piece ? PH_IN_TEXT_LEN : PH_TOP_LEN;
                  end else if (in_piece && key_score) begin
                     if (pr_dec < LEN_BITS'(FIXED32_BYTES)) begin
                        err = ERR_TRUNCATED;
                     end else begin
                        field_in = LEN_BITS'(FIXED32_BYTES);
                        phase_in = PH_IN_SCORE;
                     end
                  end else if (in_piece && key_type) begin
                     phase_in = PH_IN_TYPE;
                  end else begin
                     // Skip an unknown field
                     case (key_wire)
                        WIRE_VARINT: begin
                           phase_in = in_piece ? PH_IN_SKIP_VARINT : PH_TOP_SKIP_VARINT;
                        end
                        WIRE_LEN: begin
                           phase_in = in_piece ? PH_IN_SKIP_LEN : PH_TOP_SKIP_LEN;
                        end
                        WIRE_FIXED64, WIRE_FIXED32: begin
                           if (in_piece && (pr_dec < skip_n)) begin
                              err = ERR_TRUNCATED;
                           end else begin
                              field_in = skip_n;
                              phase_in = in_piece ? PH_IN_SKIP_BYTES : PH_TOP_SKIP_BYTES;
                           end
                        end
                        default: begin
                           err = ERR_BAD_WIRE;
                        end
                     endcase
                  end
               end else begin
                  vval_in = vnew;
                  grp_in  = grp_ff + 4'd1;
               end
            end
            PH_TOP_LEN: begin
               if (overlong) begin
                  err = ERR_OVERLONG;
               end else if (!v_more) begin
                  vval_in = '0;
                  grp_in  = '0;
                  if (v_wide) begin
                     err = ERR_OVERRUN;
                  end else begin
                     score_in = '0;
                     ptype_in = TYPE_DEFAULT;
                     if (vnew == 64'd0) begin
                        // Empty piece ends at once
                        emit_a = 1'b1;
                        item_a.kind       = KIND_PIECE_END;
                        item_a.piece_kind = TYPE_DEFAULT;
                        phase_in = PH_TOP_KEY;
                     end else begin
                        piece_in = vnew[LEN_BITS-1:0];
                        phase_in = PH_IN_KEY;
                     end
                  end
               end else begin
                  vval_in = vnew;
                  grp_in  = grp_ff + 4'd1;
               end
            end
            PH_TOP_SKIP_VARINT, PH_IN_SKIP_VARINT, PH_IN_TYPE: begin
               if (overlong) begin
                  err = ERR_OVERLONG;
               end else if (!v_more) begin
                  vval_in = '0;
                  grp_in  = '0;
                  if (phase_ff == PH_IN_TYPE) begin
                     ptype_in = vnew[31:0];
                  end
                  phase_in = in_piece ? PH_IN_KEY : PH_TOP_KEY;
               end else begin
                  vval_in = vnew;
                  grp_in  = grp_ff + 4'd1;
               end
            end
            PH_TOP_SKIP_LEN, PH_IN_SKIP_LEN, PH_IN_TEXT_LEN: begin
               if (overlong) begin
                  err = ERR_OVERLONG;
               end else if (!v_more) begin
                  vval_in = '0;
                  grp_in  = '0;
                  if (in_piece ? (vnew > 64'(pr_dec)) : v_wide) begin
                     err = ERR_OVERRUN;
                  end else begin
                     if (phase_ff == PH_IN_TEXT_LEN) begin
                        emit_a = 1'b1;
                        item_a.kind        = KIND_TEXT_BEGIN;
                        item_a.text_length = vnew[31:0];
                     end
                     field_in = vnew[LEN_BITS-1:0];
                     if (vnew == 64'd0) begin
                        phase_in = in_piece ? PH_IN_KEY : PH_TOP_KEY;
                     end else if (phase_ff == PH_IN_TEXT_LEN) begin
                        phase_in = PH_IN_TEXT;
                     end else begin
                        phase_in = in_piece ? PH_IN_SKIP_BYTES : PH_TOP_SKIP_BYTES;
                     end
                  end
               end else begin
                  vval_in = vnew;
                  grp_in  = grp_ff + 4'd1;
               end
            end
            PH_IN_TEXT: begin
               emit_a = 1'b1;
               item_a.kind       = KIND_TEXT_BYTE;
               item_a.byte_value = data_byte;
               field_in = field_ff - LEN_BITS'(1);
               if (field_ff == LEN_BITS'(1)) begin
                  phase_in = PH_IN_KEY;
               end
            end
            PH_IN_SCORE: begin
               // Little-endian score bytes
               vval_in  = vscore;
               grp_in   = grp_ff + 4'd1;
               field_in = field_ff - LEN_BITS'(1);
               if (field_ff == LEN_BITS'(1)) begin
                  score_in = vscore[31:0];
                  vval_in  = '0;
                  grp_in   = '0;
                  phase_in = PH_IN_KEY;
               end
            end
            PH_TOP_SKIP_BYTES, PH_IN_SKIP_BYTES: begin
               field_in = field_ff - LEN_BITS'(1);
               if (field_ff == LEN_BITS'(1)) begin
                  phase_in = in_piece ? PH_IN_KEY : PH_TOP_KEY;
               end
            end
            default: begin
               phase_in = PH_TOP_KEY;
            end
         endcase

         // Close the piece when its length runs out
         if ((err == ERR_NONE) && in_piece && (pr_dec == '0)) begin
            if ((phase_in == PH_IN_KEY) && (grp_in == '0)) begin
               emit_b = 1'b1;
               item_b.kind       = KIND_PIECE_END;
               item_b.score_bits = score_in;
               item_b.piece_kind = ptype_in;
               phase_in = PH_TOP_KEY;
            end else begin
               err = ERR_TRUNCATED;
            end
         end

         // Report an error, or close the buffer on its last byte
         if (err != ERR_NONE) begin
            emit_f = 1'b1;
            item_f.kind       = KIND_PARSE_ERR;
            item_f.error_code = err;
            do_clear = 1'b1;
         end else if (last) begin
            emit_f = 1'b1;
            do_clear = 1'b1;
            if ((phase_in == PH_TOP_KEY) && (grp_in == '0)) begin
               item_f.kind = KIND_PARSE_OK;
            end else if (is_inside(phase_in) ||
                         ((phase_in == PH_TOP_SKIP_BYTES) && (wire_in == WIRE_LEN))) begin
               item_f.kind       = KIND_PARSE_ERR;
               item_f.error_code = ERR_OVERRUN;
            end else begin
               item_f.kind       = KIND_PARSE_ERR;
               item_f.error_code = ERR_TRUNCATED;
            end
         end
      end

      if (do_clear) begin
         phase_in   = PH_TOP_KEY;
         vval_in    = '0;
         grp_in     = '0;
         wire_in    = '0;
         piece_in   = '0;
         field_in   = '0;
         score_in   = '0;
         ptype_in   = TYPE_DEFAULT;
         stopped_in = !stopped_ff && (err != ERR_NONE) && !last;
      end
   end

   // Pack results in order and mark the final one
   always_comb begin
      items = '0;
      res_n = '0;
      if (emit_a) begin
         items[res_n] = item_a;
         res_n = res_n + RES_CNT_W'(1);
      end
      if (emit_b) begin
         items[res_n] = item_b;
         res_n = res_n + RES_CNT_W'(1);
      end
      if (emit_f) begin
         items[res_n] = item_f;
         res_n = res_n + RES_CNT_W'(1);
      end
      if (res_n != '0) begin
         items[res_n - RES_CNT_W'(1)].last_of_run = 1'b1;
      end
      push.items = items;
      push.count = accept ? res_n : '0;
   end

   assign status.at_start = (phase_ff == PH_TOP_KEY) && (grp_ff == '0) && !stopped_ff;
   assign status.stopped  = stopped_ff;

   // Hold parser state; advance on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TOP_KEY;
         vval_ff    <= '0;
         grp_ff     <= '0;
         wire_ff    <= '0;
         piece_ff   <= '0;
         field_ff   <= '0;
         score_ff   <= '0;
         ptype_ff   <= TYPE_DEFAULT;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         vval_ff    <= vval_in;
         grp_ff     <= grp_in;
         wire_ff    <= wire_in;
         piece_ff   <= piece_in;
         field_ff   <= field_in;
         score_ff   <= score_in;
         ptype_ff   <= ptype_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== rtl/wfvp_rsp_queue.sv =====
// Result queue: takes up to three results a cycle, hands out one per beat.
`timescale 1ns / 1ps

module wfvp_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  wfvp_pkg::push_type     push,
   input  logic                   pop,
   output wfvp_pkg::rsp_item_type head,
   output logic                   head_valid,
   output logic                   room
);
   import wfvp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign room       = (count_ff <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the new results behind the tail
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (RES_CNT_W'(i) < push.count) begin
            entry_ff[wr_ptr_ff + PTR_W'(i)] <= push.items[i];
         end
      end
   end

endmodule

// ===== rtl/wire_format_vocab_parser.sv =====
// Top level of the vocabulary wire-format parser.
`timescale 1ns / 1ps

// Streams a serialized vocabulary in one byte per beat and returns text-begin,
// text-byte, piece-end and a closing parse-ok or parse-error result. Each byte
// is decoded in the cycle it is accepted, so a byte can be taken every cycle;
// a byte causes zero to three results, which go to a four-entry result queue
// drained one result per cycle. The input stalls while more than one result
// is queued, so sustained input is one byte per cycle as long as bytes average
// at most one result and the result side does not stall. After an error the
// block discards bytes silently up to the byte flagged last; after any last
// byte it is back at reset state. When a length runs past the buffer, results
// already delivered for that buffer are tentative. No clearing pass is needed.
module wire_format_vocab_parser #(
   parameter int LEN_BITS = wfvp_pkg::LEN_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_byte_value,
   output logic [31:0]        rsp_text_length,
   output logic [31:0]        rsp_score_bits,
   output logic signed [31:0] rsp_piece_kind,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last_of_run
);
   import wfvp_pkg::*;

   logic         req_fire;
   logic         rsp_fire;
   logic         room;
   push_type     push;
   status_type   status;
   rsp_item_type head;

   assign req_stall = !room;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;

   wfvp_decode #(
      .LEN_BITS (LEN_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_fire),
      .data_byte (req_data_byte),
      .last      (req_last),
      .push      (push),
      .status    (status)
   );

   wfvp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_fire),
      .head       (head),
      .head_valid (rsp_valid),
      .room       (room)
   );

   // Drive result ports from the queue head
   assign rsp_kind        = head.kind;
   assign rsp_byte_value  = head.byte_value;
   assign rsp_text_length = head.text_length;
   assign rsp_score_bits  = head.score_bits;
   assign rsp_piece_kind  = $signed(head.piece_kind);
   assign rsp_error_code  = head.error_code;
   assign rsp_last_of_run = head.last_of_run;

   // A last byte always leaves the parser at the buffer start
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last |=> status.at_start)
      else $error("parser not at buffer start after last byte");

   // A result only leaves the queue when taken
   a_no_lost_result: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_valid && !rsp_stall))
      else $error("result dropped without handshake");

   // Bytes after an error give no results
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && status.stopped |-> push.count == '0)
      else $error("result produced while discarding bytes");

endmodule

// ===== tb/sv/wire_format_vocab_parser_tb.sv =====
// Self-checking testbench for the vocabulary wire-format parser.
`timescale 1ns / 1ps

module wire_format_vocab_parser_tb;
   import wfvp_pkg::*;

   localparam int LEN_BITS      = LEN_BITS_DEFAULT;
   localparam logic [63:0] LEN_LIMIT = (64'd1 << LEN_BITS) - 64'd1;
   localparam int RESET_CYCLES  = 8;
   localparam int BEAT_TARGET   = 460;
   localparam int CALM_BEATS    = 60;
   localparam int DRAIN_SPACING = 180;
   localparam int TAIL_CYCLES   = 16;
   // Longest correct quiet stretch is a send gap plus a stall plus the tail
   localparam int QUIET_LIMIT   = 1000;
   localparam int PRINT_LIMIT   = 50;

   // Varint group outcomes
   localparam int FEED_MORE     = 0;
   localparam int FEED_DONE     = 1;
   localparam int FEED_OVERLONG = 2;

   // Wire types that are never legal
   localparam logic [2:0] WIRE_GROUP_START = 3'd3;
   localparam logic [2:0] WIRE_GROUP_END   = 3'd4;
   localparam logic [2:0] WIRE_RESERVED6   = 3'd6;
   localparam logic [2:0] WIRE_RESERVED7   = 3'd7;

   // Ways to spoil a buffer
   localparam int FLAW_NONE     = -1;
   localparam int FLAW_NOISE    = 0;
   localparam int FLAW_SKEW     = 1;
   localparam int FLAW_CUT      = 2;
   localparam int FLAW_BAD_WIRE = 3;
   localparam int FLAW_OVERLONG = 4;
   localparam int FLAW_WIDE     = 5;
   localparam int FLAW_FLIP     = 6;

   typedef enum logic [3:0] {
      PH_TOP_KEY, PH_TOP_LEN, PH_TOP_SKIP_VARINT, PH_TOP_SKIP_LEN, PH_TOP_SKIP_BYTES,
      PH_IN_KEY, PH_IN_TEXT_LEN, PH_IN_TEXT, PH_IN_SCORE, PH_IN_TYPE,
      PH_IN_SKIP_VARINT, PH_IN_SKIP_LEN, PH_IN_SKIP_BYTES
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain_first;
   } byte_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'd0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_kind;
   logic [7:0]         rsp_byte_value;
   logic [31:0]        rsp_text_length;
   logic [31:0]        rsp_score_bits;
   logic signed [31:0] rsp_piece_kind;
   logic [2:0]         rsp_error_code;
   logic               rsp_last_of_run;

   wire_format_vocab_parser #(.LEN_BITS(LEN_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_byte_value  (rsp_byte_value),
      .rsp_text_length (rsp_text_length),
      .rsp_score_bits  (rsp_score_bits),
      .rsp_piece_kind  (rsp_piece_kind),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   // Parser shadow state
   parse_phase_type m_phase;
   logic [63:0]     acc_value;
   int              acc_shift;
   logic [2:0]      key_wire;
   logic [63:0]     piece_left;
   logic [63:0]     field_left;
   logic [31:0]     cur_score;
   logic [31:0]     cur_type;
   logic            discarding;

   rsp_item_type    run_items [MAX_RESULTS];
   int              run_count;
   rsp_item_type    expected_results [$];

   // Stimulus store
   byte_beat_type   pending_beats [$];
   logic [7:0]      buf_bytes [$];
   logic [7:0]      body_bytes [$];
   int              total_beats = 0;
   int              drain_mark = 150;

   int              beats_taken = 0;
   int              results_seen = 0;
   int              mismatch_count = 0;
   int              quiet_cycles = 0;
   logic [31:0]     cycle_count = 32'd0;
   int              send_gap = 0;
   int              stall_left = 0;
   byte_beat_type   beat_out;
   rsp_item_type    want;

   function automatic void reset_parser();
      m_phase    = PH_TOP_KEY;
      acc_value  = 64'd0;
      acc_shift  = 0;
      key_wire   = WIRE_VARINT;
      piece_left = 64'd0;
      field_left = 64'd0;
      cur_score  = 32'd0;
      cur_type   = TYPE_DEFAULT;
      discarding = 1'b0;
   endfunction

   function automatic parse_phase_type pick_phase(input logic inner,
                                                  input parse_phase_type in_ph,
                                                  input parse_phase_type top_ph);
      if (inner) return in_ph;
      return top_ph;
   endfunction

   function automatic void add_result(input rsp_kind_type kind, input logic [7:0] bval,
                                      input logic [63:0] len, input logic [31:0] score,
                                      input logic [31:0] ptype, input err_code_type err);
      if (run_count >= MAX_RESULTS) return;
      run_items[run_count].kind        = kind;
      run_items[run_count].byte_value  = bval;
      run_items[run_count].text_length = len[31:0];
      run_items[run_count].score_bits  = score;
      run_items[run_count].piece_kind  = ptype;
      run_items[run_count].error_code  = err;
      run_items[run_count].last_of_run = 1'b0;
      run_count++;
   endfunction

   // Fold one 7-bit group into the accumulator
   function automatic int feed_group(input logic [7:0] b);
      if (acc_shift < 64) acc_value = acc_value | ({57'd0, b[6:0]} << acc_shift);
      if (!b[7]) return FEED_DONE;
      acc_shift = acc_shift + 7;
      if (acc_shift > 63) return FEED_OVERLONG;
      return FEED_MORE;
   endfunction

   function automatic logic [63:0] take_value();
      logic [63:0] v;
      v = acc_value;
      acc_value = 64'd0;
      acc_shift = 0;
      return v;
   endfunction

   function automatic err_code_type start_skip(input logic [2:0] wtype, input logic inner);
      logic [63:0] n;
      if (wtype == WIRE_VARINT) begin
         m_phase = pick_phase(inner, PH_IN_SKIP_VARINT, PH_TOP_SKIP_VARINT);
         return ERR_NONE;
      end
      if (wtype == WIRE_LEN) begin
         m_phase = pick_phase(inner, PH_IN_SKIP_LEN, PH_TOP_SKIP_LEN);
         return ERR_NONE;
      end
      if (wtype == WIRE_FIXED64) n = 64'(FIXED64_BYTES);
      else if (wtype == WIRE_FIXED32) n = 64'(FIXED32_BYTES);
      else return ERR_BAD_WIRE;
      if (inner && piece_left < n) return ERR_TRUNCATED;
      field_left = n;
      m_phase = pick_phase(inner, PH_IN_SKIP_BYTES, PH_TOP_SKIP_BYTES);
      return ERR_NONE;
   endfunction

   // Advance the shadow parser by one byte; return the error it raises
   function automatic err_code_type consume_byte(input logic [7:0] b);
      logic         inner;
      logic [63:0]  v;
      logic [60:0]  fld;
      logic [2:0]   wtype;
      int           r;
      err_code_type e;
      inner = (m_phase >= PH_IN_KEY) && (m_phase <= PH_IN_SKIP_BYTES);
      if (inner) piece_left = piece_left - 64'd1;
      case (m_phase)
         PH_TOP_KEY, PH_IN_KEY: begin
            r = feed_group(b);
            if (r == FEED_OVERLONG) return ERR_OVERLONG;
            if (r == FEED_DONE) begin
               v = take_value();
               wtype = v[2:0];
               fld = v[63:3];
               key_wire = wtype;
               if (!inner) begin
                  if (fld == FIELD_TEXT && wtype == WIRE_LEN) begin
                     m_phase = PH_TOP_LEN;
                  end else begin
                     e = start_skip(wtype, 1'b0);
                     if (e != ERR_NONE) return e;
                  end
               end else if (fld == FIELD_TEXT && wtype == WIRE_LEN) begin
                  m_phase = PH_IN_TEXT_LEN;
               end else if (fld == FIELD_SCORE && wtype == WIRE_FIXED32) begin
                  if (piece_left < FIXED32_BYTES) return ERR_TRUNCATED;
                  field_left = 64'(FIXED32_BYTES);
                  m_phase = PH_IN_SCORE;
               end else if (fld == FIELD_TYPE && wtype == WIRE_VARINT) begin
                  m_phase = PH_IN_TYPE;
               end else begin
                  e = start_skip(wtype, 1'b1);
                  if (e != ERR_NONE) return e;
               end
            end
         end
         PH_TOP_LEN: begin
            r = feed_group(b);
            if (r == FEED_OVERLONG) return ERR_OVERLONG;
            if (r == FEED_DONE) begin
               v = take_value();
               if (v > LEN_LIMIT) return ERR_OVERRUN;
               cur_score = 32'd0;
               cur_type = TYPE_DEFAULT;
               if (v == 64'd0) begin
                  add_result(KIND_PIECE_END, 8'd0, 64'd0, cur_score, cur_type, ERR_NONE);
                  m_phase = PH_TOP_KEY;
               end else begin
                  piece_left = v;
                  m_phase = PH_IN_KEY;
               end
            end
         end
         PH_TOP_SKIP_VARINT, PH_IN_SKIP_VARINT, PH_IN_TYPE: begin
            r = feed_group(b);
            if (r == FEED_OVERLONG) return ERR_OVERLONG;
            if (r == FEED_DONE) begin
               v = take_value();
               if (m_phase == PH_IN_TYPE) cur_type = v[31:0];
               m_phase = pick_phase(inner, PH_IN_KEY, PH_TOP_KEY);
            end
         end
         PH_TOP_SKIP_LEN, PH_IN_SKIP_LEN, PH_IN_TEXT_LEN: begin
            r = feed_group(b);
            if (r == FEED_OVERLONG) return ERR_OVERLONG;
            if (r == FEED_DONE) begin
               v = take_value();
               if (inner ? (v > piece_left) : (v > LEN_LIMIT)) return ERR_OVERRUN;
               if (m_phase == PH_IN_TEXT_LEN)
                  add_result(KIND_TEXT_BEGIN, 8'd0, v, 32'd0, 32'd0, ERR_NONE);
               field_left = v;
               if (v == 64'd0) m_phase = pick_phase(inner, PH_IN_KEY, PH_TOP_KEY);
               else if (m_phase == PH_IN_TEXT_LEN) m_phase = PH_IN_TEXT;
               else m_phase = pick_phase(inner, PH_IN_SKIP_BYTES, PH_TOP_SKIP_BYTES);
            end
         end
         PH_IN_TEXT: begin
            add_result(KIND_TEXT_BYTE, b, 64'd0, 32'd0, 32'd0, ERR_NONE);
            field_left = field_left - 64'd1;
            if (field_left == 64'd0) m_phase = PH_IN_KEY;
         end
         PH_IN_SCORE: begin
            // Score bytes arrive little-endian
            acc_value = acc_value | ({56'd0, b} << (8 * (acc_shift % 4)));
            acc_shift = acc_shift + 1;
            field_left = field_left - 64'd1;
            if (field_left == 64'd0) begin
               v = take_value();
               cur_score = v[31:0];
               m_phase = PH_IN_KEY;
            end
         end
         PH_TOP_SKIP_BYTES, PH_IN_SKIP_BYTES: begin
            field_left = field_left - 64'd1;
            if (field_left == 64'd0) m_phase = pick_phase(inner, PH_IN_KEY, PH_TOP_KEY);
         end
         default: m_phase = PH_TOP_KEY;
      endcase
      // Close the piece once its declared length is used up
      if (inner && piece_left == 64'd0) begin
         if (m_phase == PH_IN_KEY && acc_shift == 0) begin
            add_result(KIND_PIECE_END, 8'd0, 64'd0, cur_score, cur_type, ERR_NONE);
            m_phase = PH_TOP_KEY;
         end else begin
            return ERR_TRUNCATED;
         end
      end
      return ERR_NONE;
   endfunction

   // Queue the results that one accepted byte causes
   function automatic void predict_beat(input logic [7:0] b, input logic last);
      err_code_type e;
      run_count = 0;
      if (discarding) begin
         if (last) reset_parser();
         return;
      end
      e = consume_byte(b);
      if (e != ERR_NONE) begin
         add_result(KIND_PARSE_ERR, 8'd0, 64'd0, 32'd0, 32'd0, e);
         reset_parser();
         if (!last) discarding = 1'b1;
      end else if (last) begin
         if (m_phase == PH_TOP_KEY && acc_shift == 0)
            add_result(KIND_PARSE_OK, 8'd0, 64'd0, 32'd0, 32'd0, ERR_NONE);
         else if (m_phase >= PH_IN_KEY ||
                  (m_phase == PH_TOP_SKIP_BYTES && key_wire == WIRE_LEN))
            add_result(KIND_PARSE_ERR, 8'd0, 64'd0, 32'd0, 32'd0, ERR_OVERRUN);
         else
            add_result(KIND_PARSE_ERR, 8'd0, 64'd0, 32'd0, 32'd0, ERR_TRUNCATED);
         reset_parser();
      end
      if (run_count > 0) run_items[run_count - 1].last_of_run = 1'b1;
      for (int i = 0; i < run_count; i++)
         expected_results.insert(expected_results.size(), run_items[i]);
   endfunction

   // Buffer construction
   function automatic void put_byte(input logic to_body, input logic [7:0] b);
      if (to_body) body_bytes.insert(body_bytes.size(), b);
      else buf_bytes.insert(buf_bytes.size(), b);
   endfunction

   function automatic void put_base128(input logic to_body, input logic [63:0] v);
      logic [63:0] rest;
      rest = v;
      while (rest > 64'd127) begin
         put_byte(to_body, {1'b1, rest[6:0]});
         rest = rest >> 7;
      end
      put_byte(to_body, {1'b0, rest[6:0]});
   endfunction

   function automatic logic [63:0] random_varint_value();
      case ($urandom_range(0, 3))
         0: return 64'($urandom_range(0, 127));
         1: return 64'($urandom_range(0, 70000));
         2: return {32'd0, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [31:0] random_field_number();
      case ($urandom_range(0, 3))
         0: return $urandom_range(1, 5);
         1: return $urandom_range(6, 40);
         2: return 32'd1 + 32'd16 * $urandom_range(1, 8);
         default: return $urandom_range(1, 32'h000F_FFFF);
      endcase
   endfunction

   function automatic logic [2:0] random_legal_wire();
      case ($urandom_range(0, 3))
         0: return WIRE_VARINT;
         1: return WIRE_FIXED64;
         2: return WIRE_LEN;
         default: return WIRE_FIXED32;
      endcase
   endfunction

   function automatic logic [2:0] random_bad_wire();
      case ($urandom_range(0, 3))
         0: return WIRE_GROUP_START;
         1: return WIRE_GROUP_END;
         2: return WIRE_RESERVED6;
         default: return WIRE_RESERVED7;
      endcase
   endfunction

   // Write a key and a payload that fits its wire type
   function automatic void put_field(input logic to_body, input logic [31:0] fnum,
                                     input logic [2:0] wtype);
      int n;
      put_base128(to_body, {29'd0, fnum, wtype});
      case (wtype)
         WIRE_VARINT:  put_base128(to_body, random_varint_value());
         WIRE_FIXED64: repeat (FIXED64_BYTES) put_byte(to_body, 8'($urandom));
         WIRE_FIXED32: repeat (FIXED32_BYTES) put_byte(to_body, 8'($urandom));
         WIRE_LEN: begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
            put_base128(to_body, 64'(n));
            repeat (n) put_byte(to_body, 8'($urandom));
         end
         default: ;
      endcase
   endfunction

   function automatic void put_piece(input logic skewed);
      int pick;
      int len;
      int skew_amt;
      body_bytes.delete();
      repeat ($urandom_range(0, 4)) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) put_field(1'b1, FIELD_TEXT, WIRE_LEN);
         else if (pick < 55) put_field(1'b1, FIELD_SCORE, WIRE_FIXED32);
         else if (pick < 75) put_field(1'b1, FIELD_TYPE, WIRE_VARINT);
         else put_field(1'b1, random_field_number(), random_legal_wire());
      end
      len = body_bytes.size();
      if (skewed) begin
         skew_amt = $urandom_range(0, 6);
         len = len + skew_amt - 3;
         if (len < 0) len = 0;
      end
      put_base128(1'b0, {29'd0, 32'(FIELD_TEXT), WIRE_LEN});
      put_base128(1'b0, 64'(len));
      foreach (body_bytes[i]) buf_bytes.insert(buf_bytes.size(), body_bytes[i]);
   endfunction

   // Move the buffer into the beat queue, flagging the byte at cut as last
   function automatic void commit_buffer(input int cut);
      byte_beat_type beat;
      for (int i = 0; i <= cut; i++) begin
         beat.data = buf_bytes[i];
         beat.last = (i == cut);
         beat.drain_first = (i == 0) && (total_beats >= drain_mark);
         if (beat.drain_first) drain_mark += DRAIN_SPACING;
         pending_beats.insert(pending_beats.size(), beat);
         total_beats++;
      end
   endfunction

   function automatic void build_buffer();
      int flaw;
      int pos;
      int cut;
      logic [63:0] wide;
      buf_bytes.delete();
      flaw = ($urandom_range(0, 99) < 30) ? $urandom_range(FLAW_NOISE, FLAW_FLIP) : FLAW_NONE;
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(1, 8)) put_byte(1'b0, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) != 0) put_piece(flaw == FLAW_SKEW);
            else put_field(1'b0, random_field_number(), random_legal_wire());
         end
         pos = $urandom_range(0, 1) ? buf_bytes.size() : $urandom_range(0, buf_bytes.size());
         case (flaw)
            FLAW_BAD_WIRE:
               buf_bytes.insert(pos, {1'b0, 4'($urandom_range(0, 15)), random_bad_wire()});
            FLAW_OVERLONG: begin
               repeat (10) begin
                  buf_bytes.insert(pos, 8'h80 | 8'($urandom));
                  pos++;
               end
               buf_bytes.insert(pos, 8'h7F & 8'($urandom));
            end
            FLAW_WIDE: begin
               // A length just fitting the width, or one that needs 33 to 36 bits
               wide = $urandom_range(0, 2) == 0 ? LEN_LIMIT :
                      {28'd0, 4'($urandom_range(1, 15)), $urandom};
               put_base128(1'b0, {29'd0, 32'($urandom_range(0, 1) ? FIELD_TEXT : 5), WIRE_LEN});
               put_base128(1'b0, wide);
               repeat ($urandom_range(0, 3)) put_byte(1'b0, 8'($urandom));
            end
            FLAW_FLIP: buf_bytes[$urandom_range(0, buf_bytes.size() - 1)] = 8'($urandom);
            default: ;
         endcase
      end
      cut = buf_bytes.size() - 1;
      if (flaw == FLAW_CUT) cut = $urandom_range(0, buf_bytes.size() - 1);
      commit_buffer(cut);
   endfunction

   function automatic logic idle_allowed();
      return pending_beats.size() >= CALM_BEATS && cycle_count[7:6] != 2'b11;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("mismatch at result %0d: %s", results_seen, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val) report_mismatch($sformatf("%s got %0h, want %0h", name, got, exp_val));
   endtask

   // Drive request beats; hold each until taken, then idle or send the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_beats.size() == 0) begin
            req_valid <= 1'b0;
         end else if (pending_beats[0].drain_first &&
                      (req_valid || expected_results.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            beat_out = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= beat_out.data;
            req_last <= beat_out.last;
            if (idle_allowed() && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
         end
      end
   end

   // Stall the result side in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 10);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on each taken byte, then check each taken result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_beat(req_data_byte, req_last);
            beats_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want = expected_results.pop_front();
               check_field("kind", {29'd0, rsp_kind}, {29'd0, want.kind});
               check_field("byte_value", {24'd0, rsp_byte_value}, {24'd0, want.byte_value});
               check_field("text_length", rsp_text_length, want.text_length);
               check_field("score_bits", rsp_score_bits, want.score_bits);
               check_field("piece_kind", rsp_piece_kind, want.piece_kind);
               check_field("error_code", {29'd0, rsp_error_code}, {29'd0, want.error_code});
               check_field("last_of_run", {31'd0, rsp_last_of_run}, {31'd0, want.last_of_run});
            end
            results_seen++;
         end
      end
   end

   // Abort when nothing moves on either side for too long
   always @(posedge clock) begin
      cycle_count <= cycle_count + 32'd1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset_parser();
      // Empty piece, then a bad wire type on the last byte
      buf_bytes = '{8'h0A, 8'h00, 8'h0B};
      commit_buffer(buf_bytes.size() - 1);
      // Piece with one text byte and a score; it closes on the last byte
      buf_bytes = '{8'h0A, 8'h08, 8'h0A, 8'h01, 8'hFF, 8'h15, 8'h00, 8'h00, 8'h80, 8'hFF};
      commit_buffer(buf_bytes.size() - 1);
      // Varint key whose value is cut off at the buffer end
      buf_bytes = '{8'h08};
      commit_buffer(buf_bytes.size() - 1);
      // Piece length one past the width limit
      buf_bytes = '{8'h0A, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
      commit_buffer(buf_bytes.size() - 1);
      while (total_beats < BEAT_TARGET) build_buffer();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      while (beats_taken < total_beats) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wfvp_pkg.sv
rtl/wfvp_decode.sv
rtl/wfvp_rsp_queue.sv
rtl/wire_format_vocab_parser.sv
tb/sv/wire_format_vocab_parser_tb.sv
